FILE: design/assert_macros.svh
// Assertion macros shared by the stack unit RTL.
// Standalone header; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high
`define FDSU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define FDSU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDSU_ASSERT(label, clk, rst, prop, msg)
`define FDSU_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

FILE: design/fdsu_pkg.sv
// Shared types, sizes and operation codes of the dual stack unit.
// No dependencies; used by fdsu_exec and forth_dual_stack_unit.
`default_nettype none

package fdsu_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int FUNC_W      = 4;
  localparam int PICK_W      = 6;
  // room for count - 1 - pick index without losing the sign
  localparam int IDX_W       = ((CNT_W > PICK_W) ? CNT_W : PICK_W) + 1;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [PICK_W-1:0]     pick_t;

  localparam count_t FULL_COUNT = CNT_W'(STACK_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH        = 4'd0,
    FN_DROP        = 4'd1,
    FN_DUP         = 4'd2,
    FN_SWAP        = 4'd3,
    FN_PICK        = 4'd4,
    FN_EMPTY_TEST  = 4'd5,
    FN_WORK_TO_RET = 4'd6,
    FN_RET_TO_WORK = 4'd7,
    FN_COPY_TO_RET = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef struct packed {
    func_t func;
    word_t push_value;
    pick_t pick_index;
  } item_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
  } ram_wr_t;

  typedef struct packed {
    ram_wr_t work_wr;
    ram_wr_t ret_wr;
    count_t  work_cnt;
    word_t   work_top;
    count_t  ret_cnt;
    word_t   ret_top;
    word_t   value;
    status_t status;
  } exec_res_t;

endpackage

`default_nettype wire

FILE: design/fdsu_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies; read returns the old word on a same-address write.
`default_nettype none

module fdsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/fdsu_exec.sv
// Operation logic of the dual stack unit: status, next stack state, RAM writes.
// Depends on fdsu_pkg. Tops of stack live in registers, the rest in RAM.
`default_nettype none

module fdsu_exec (
  input  fdsu_pkg::item_t     item,
  input  fdsu_pkg::count_t    work_cnt,
  input  fdsu_pkg::word_t     work_top,
  input  fdsu_pkg::word_t     work_rd,
  input  fdsu_pkg::count_t    ret_cnt,
  input  fdsu_pkg::word_t     ret_top,
  input  fdsu_pkg::word_t     ret_rd,
  output fdsu_pkg::exec_res_t res
);
  import fdsu_pkg::*;

  logic    w_empty, w_full, w_two, r_empty, r_full, pick_oob;
  logic    w_push, w_pop, r_push, r_pop, swap_op, moved;
  word_t   w_push_word, moved_word;
  status_t st;
  count_t  wc_m1, wc_m2, rc_m1, wc_next, rc_next;
  word_t   wt_next, rt_next;

  assign w_empty  = (work_cnt == '0);
  assign w_full   = (work_cnt >= FULL_COUNT);
  assign w_two    = (work_cnt >= count_t'(2));
  assign r_empty  = (ret_cnt == '0);
  assign r_full   = (ret_cnt >= FULL_COUNT);
  assign pick_oob = (IDX_W'(item.pick_index) >= IDX_W'(work_cnt));

  assign wc_m1 = work_cnt - count_t'(1);
  assign wc_m2 = work_cnt - count_t'(2);
  assign rc_m1 = ret_cnt - count_t'(1);

  // decode the operation and check bounds
  always_comb begin
    st          = ST_OK;
    w_push      = 1'b0;
    w_pop       = 1'b0;
    r_push      = 1'b0;
    r_pop       = 1'b0;
    swap_op     = 1'b0;
    moved       = 1'b0;
    w_push_word = item.push_value;
    moved_word  = work_top;
    unique case (item.func)
      FN_PUSH: begin
        if (w_full) st = ST_OVER;
        else w_push = 1'b1;
      end
      FN_DROP: begin
        if (w_empty) st = ST_UNDER;
        else begin
          w_pop = 1'b1;
          moved = 1'b1;
        end
      end
      FN_DUP: begin
        priority if (w_empty) st = ST_UNDER;
        else if (w_full) st = ST_OVER;
        else begin
          w_push      = 1'b1;
          w_push_word = work_top;
        end
      end
      FN_SWAP: begin
        if (!w_two) st = ST_UNDER;
        else swap_op = 1'b1;
      end
      FN_PICK: begin
        priority if (pick_oob) st = ST_UNDER;
        else if (w_full) st = ST_OVER;
        else begin
          w_push      = 1'b1;
          w_push_word = (item.pick_index == '0) ? work_top : work_rd;
        end
      end
      FN_EMPTY_TEST: begin
        if (w_full) st = ST_OVER;
        else begin
          w_push      = 1'b1;
          w_push_word = WORD_WIDTH'(w_empty);
        end
      end
      FN_WORK_TO_RET: begin
        priority if (w_empty) st = ST_UNDER;
        else if (r_full) st = ST_OVER;
        else begin
          w_pop  = 1'b1;
          r_push = 1'b1;
          moved  = 1'b1;
        end
      end
      FN_RET_TO_WORK: begin
        priority if (r_empty) st = ST_UNDER;
        else if (w_full) st = ST_OVER;
        else begin
          r_pop       = 1'b1;
          w_push      = 1'b1;
          w_push_word = ret_top;
          moved       = 1'b1;
          moved_word  = ret_top;
        end
      end
      FN_COPY_TO_RET: begin
        priority if (w_empty) st = ST_UNDER;
        else if (r_full) st = ST_OVER;
        else begin
          r_push = 1'b1;
          moved  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // spill the old top into RAM on a push; swap writes the old top under it
  assign res.work_wr.we    = (w_push && !w_empty) || swap_op;
  assign res.work_wr.waddr = swap_op ? wc_m2[ADDR_W-1:0] : wc_m1[ADDR_W-1:0];
  assign res.work_wr.wdata = work_top;

  assign res.ret_wr.we    = r_push && !r_empty;
  assign res.ret_wr.waddr = rc_m1[ADDR_W-1:0];
  assign res.ret_wr.wdata = ret_top;

  // next counts and tops; a pop refills the top from the RAM word
  always_comb begin
    if (w_push) wc_next = work_cnt + count_t'(1);
    else if (w_pop) wc_next = wc_m1;
    else wc_next = work_cnt;

    if (w_push) wt_next = w_push_word;
    else if (w_pop || swap_op) wt_next = work_rd;
    else wt_next = work_top;

    if (r_push) rc_next = ret_cnt + count_t'(1);
    else if (r_pop) rc_next = rc_m1;
    else rc_next = ret_cnt;

    if (r_push) rt_next = work_top;
    else if (r_pop) rt_next = ret_rd;
    else rt_next = ret_top;
  end

  assign res.work_cnt = wc_next;
  assign res.work_top = wt_next;
  assign res.ret_cnt  = rc_next;
  assign res.ret_top  = rt_next;
  assign res.status   = st;
  assign res.value    = moved ? moved_word : ((wc_next == '0) ? '0 : wt_next);

endmodule

`default_nettype wire

FILE: design/forth_dual_stack_unit.sv
// Top level of the dual stack unit: handshakes, stack RAMs, state and result registers.
// Depends on fdsu_pkg, fdsu_ram, fdsu_exec and assert_macros.svh.
//
// Forth work stack and return stack of STACK_DEPTH words each, one operation per
// beat. The unit takes one operation every clock cycle while out_ready does not stall
// the result register, and hands each result out through the execute register, then
// the result register, with no bubbles under back-to-back traffic. Each stack keeps
// its top word in a register and the words below it in a RAM with one write and one
// registered read port; the read for an operation is issued as it is accepted, from
// the state left by the operation ahead of it, and a word that operation writes in
// the same cycle is forwarded around the RAM. No clearing pass is needed after
// reset: only words below the stack depth are ever used.
`default_nettype none
`include "assert_macros.svh"

module forth_dual_stack_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [fdsu_pkg::FUNC_W-1:0] func,
  input  fdsu_pkg::word_t          push_value,
  input  fdsu_pkg::pick_t          pick_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fdsu_pkg::word_t          value_out,
  output fdsu_pkg::count_t         work_depth,
  output fdsu_pkg::count_t         return_depth,
  output logic [1:0]               status
);
  import fdsu_pkg::*;

  logic      out_adv, ex_fire, in_fire, ex_valid;
  item_t     ex_item;
  count_t    work_cnt, ret_cnt, nxt_wcnt, nxt_rcnt, wn_m2, rn_m2;
  word_t     work_top, ret_top;
  word_t     w_ram_rdata, r_ram_rdata, work_rd, ret_rd;
  logic      w_fwd, r_fwd, w_fwd_next, r_fwd_next;
  word_t     w_fwd_data, r_fwd_data;
  logic      work_we, ret_we;
  addr_t     w_raddr, r_raddr;
  logic [IDX_W-1:0] pick_pos;
  exec_res_t res;

  // handshake: execute advances when the result register is free or draining
  assign out_adv  = !out_valid || out_ready;
  assign ex_fire  = ex_valid && out_adv;
  assign in_ready = !ex_valid || out_adv;
  assign in_fire  = in_valid && in_ready;

  // stack state as the incoming beat will see it
  assign nxt_wcnt = ex_fire ? res.work_cnt : work_cnt;
  assign nxt_rcnt = ex_fire ? res.ret_cnt : ret_cnt;
  assign wn_m2    = nxt_wcnt - count_t'(2);
  assign rn_m2    = nxt_rcnt - count_t'(2);
  assign pick_pos = IDX_W'(nxt_wcnt) - IDX_W'(1) - IDX_W'(pick_index);

  // read address: picked word for pick, else the word under the top
  assign w_raddr = (func_t'(func) == FN_PICK) ? pick_pos[ADDR_W-1:0] : wn_m2[ADDR_W-1:0];
  assign r_raddr = rn_m2[ADDR_W-1:0];

  assign work_we = ex_fire && res.work_wr.we;
  assign ret_we  = ex_fire && res.ret_wr.we;

  // forward a word written in the same cycle as its read
  assign w_fwd_next = work_we && (res.work_wr.waddr == w_raddr);
  assign r_fwd_next = ret_we && (res.ret_wr.waddr == r_raddr);

  fdsu_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_work_ram (
    .clk  (clk),
    .we   (work_we),
    .waddr(res.work_wr.waddr),
    .wdata(res.work_wr.wdata),
    .re   (in_fire),
    .raddr(w_raddr),
    .rdata(w_ram_rdata)
  );

  fdsu_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_ret_ram (
    .clk  (clk),
    .we   (ret_we),
    .waddr(res.ret_wr.waddr),
    .wdata(res.ret_wr.wdata),
    .re   (in_fire),
    .raddr(r_raddr),
    .rdata(r_ram_rdata)
  );

  assign work_rd = w_fwd ? w_fwd_data : w_ram_rdata;
  assign ret_rd  = r_fwd ? r_fwd_data : r_ram_rdata;

  fdsu_exec u_exec (
    .item    (ex_item),
    .work_cnt(work_cnt),
    .work_top(work_top),
    .work_rd (work_rd),
    .ret_cnt (ret_cnt),
    .ret_top (ret_top),
    .ret_rd  (ret_rd),
    .res     (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      work_cnt  <= '0;
      ret_cnt   <= '0;
    end else begin
      if (in_ready) ex_valid <= in_valid;
      if (out_adv) out_valid <= ex_valid;
      if (ex_fire) begin
        work_cnt <= res.work_cnt;
        ret_cnt  <= res.ret_cnt;
      end
    end
  end

  // capture the accepted beat and its forwarding info
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_item.func       <= func_t'(func);
      ex_item.push_value <= push_value;
      ex_item.pick_index <= pick_index;
      w_fwd              <= w_fwd_next;
      w_fwd_data         <= res.work_wr.wdata;
      r_fwd              <= r_fwd_next;
      r_fwd_data         <= res.ret_wr.wdata;
    end
  end

  // commit tops and load the result register
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      work_top     <= res.work_top;
      ret_top      <= res.ret_top;
      value_out    <= res.value;
      work_depth   <= res.work_cnt;
      return_depth <= res.ret_cnt;
      status       <= res.status;
    end
  end

  `FDSU_ASSERT(a_accept_moves_ex, clk, rst, (in_fire && ex_valid) |-> ex_fire, "beat accepted over a stalled execute stage")
  `FDSU_ASSERT(a_count_hold, clk, rst, !ex_fire |=> ($stable(work_cnt) && $stable(ret_cnt)), "stack depth changed without an executed beat")
  `FDSU_ASSERT(a_fault_no_write, clk, rst, (ex_valid && (res.status != ST_OK)) |-> (!res.work_wr.we && !res.ret_wr.we), "faulted operation writes a stack RAM")
  `FDSU_ASSERT(a_depth_bound, clk, rst, ex_fire |=> ((work_cnt <= FULL_COUNT) && (ret_cnt <= FULL_COUNT)), "stack depth past its bound")
  `FDSU_ASSERT_RST(a_reset_clear, clk, rst |=> (!out_valid && !ex_valid && (work_cnt == '0) && (ret_cnt == '0)), "reset left state behind")

endmodule

`default_nettype wire

FILE: verif/forth_dual_stack_unit_tb.sv
// Self-checking testbench for forth_dual_stack_unit: directed corner beats, then random runs
// shaped to fill and drain both stacks, checked against an in-bench stack predictor.
// Depends on fdsu_pkg and the forth_dual_stack_unit RTL.
module forth_dual_stack_unit_tb;
  import fdsu_pkg::*;

  // Op codes the unit treats as no-ops
  localparam logic [FUNC_W-1:0] FN_NOP_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_NOP_HI = 4'd15;

  localparam int RANDOM_OPS    = 1150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 13;
  localparam int HOLD_AT_BEAT  = 400;
  localparam int HOLD_CYCLES   = 150;
  localparam int CALM_FIRST    = 700;
  localparam int CALM_LAST     = 850;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_TO_RET, MODE_FROM_RET, MODE_MIX} gen_mode_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    word_t             value;
    pick_t             pidx;
    bit                wait_drain;
  } stack_op_t;

  typedef struct {
    word_t      value;
    count_t     wdepth;
    count_t     rdepth;
    logic [1:0] status;
  } stack_res_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func = '0;
  word_t             push_value = '0;
  pick_t             pick_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  word_t             value_out;
  count_t            work_depth;
  count_t            return_depth;
  logic [1:0]        status;

  // Predicted stack contents
  word_t work_stk [STACK_DEPTH];
  word_t ret_stk  [STACK_DEPTH];
  int    work_cnt = 0;
  int    ret_cnt  = 0;

  stack_op_t  pending_ops [$];
  stack_res_t expected_res [$];
  stack_op_t  cur_op;
  int         queued_total = 0;
  int         beats_in = 0;
  int         beats_out = 0;
  int         errors = 0;
  int         cycle_count = 0;

  forth_dual_stack_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .push_value   (push_value),
    .pick_index   (pick_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_out    (value_out),
    .work_depth   (work_depth),
    .return_depth (return_depth),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one op to the predicted stacks and return the result it should produce
  function automatic stack_res_t apply_stack_op(stack_op_t op);
    stack_res_t r;
    word_t      moved_word;
    bit         moved;
    bit         wfull;
    bit         rfull;
    logic [1:0] st;
    moved      = 1'b0;
    moved_word = '0;
    st         = ST_OK;
    wfull      = work_cnt >= STACK_DEPTH;
    rfull      = ret_cnt >= STACK_DEPTH;
    case (op.func)
      FN_PUSH: begin
        if (wfull) st = ST_OVER;
        else begin
          work_stk[work_cnt] = op.value;
          work_cnt++;
        end
      end
      FN_DROP: begin
        if (work_cnt == 0) st = ST_UNDER;
        else begin
          work_cnt--;
          moved_word = work_stk[work_cnt];
          moved = 1'b1;
        end
      end
      FN_DUP: begin
        if (work_cnt == 0) st = ST_UNDER;
        else if (wfull) st = ST_OVER;
        else begin
          work_stk[work_cnt] = work_stk[work_cnt-1];
          work_cnt++;
        end
      end
      FN_SWAP: begin
        if (work_cnt < 2) st = ST_UNDER;
        else begin
          moved_word = work_stk[work_cnt-1];
          work_stk[work_cnt-1] = work_stk[work_cnt-2];
          work_stk[work_cnt-2] = moved_word;
        end
      end
      FN_PICK: begin
        if (int'(op.pidx) >= work_cnt) st = ST_UNDER;
        else if (wfull) st = ST_OVER;
        else begin
          work_stk[work_cnt] = work_stk[work_cnt-1-int'(op.pidx)];
          work_cnt++;
        end
      end
      FN_EMPTY_TEST: begin
        if (wfull) st = ST_OVER;
        else begin
          work_stk[work_cnt] = word_t'(work_cnt == 0);
          work_cnt++;
        end
      end
      FN_WORK_TO_RET: begin
        if (work_cnt == 0) st = ST_UNDER;
        else if (rfull) st = ST_OVER;
        else begin
          work_cnt--;
          moved_word = work_stk[work_cnt];
          ret_stk[ret_cnt] = moved_word;
          ret_cnt++;
          moved = 1'b1;
        end
      end
      FN_RET_TO_WORK: begin
        if (ret_cnt == 0) st = ST_UNDER;
        else if (wfull) st = ST_OVER;
        else begin
          ret_cnt--;
          moved_word = ret_stk[ret_cnt];
          work_stk[work_cnt] = moved_word;
          work_cnt++;
          moved = 1'b1;
        end
      end
      FN_COPY_TO_RET: begin
        if (work_cnt == 0) st = ST_UNDER;
        else if (rfull) st = ST_OVER;
        else begin
          moved_word = work_stk[work_cnt-1];
          ret_stk[ret_cnt] = moved_word;
          ret_cnt++;
          moved = 1'b1;
        end
      end
      default: ;
    endcase
    if (moved) r.value = moved_word;
    else r.value = (work_cnt == 0) ? '0 : work_stk[work_cnt-1];
    r.wdepth = count_t'(work_cnt);
    r.rdepth = count_t'(ret_cnt);
    r.status = st;
    return r;
  endfunction

  // Random op whose mix of codes depends on the run's mode
  function automatic stack_op_t make_op(gen_mode_t mode);
    stack_op_t op;
    int        roll;
    roll = $urandom_range(99);
    op.value = $urandom();
    op.pidx = ($urandom_range(3) == 0) ? pick_t'($urandom_range(63)) : pick_t'($urandom_range(7));
    op.wait_drain = 1'b0;
    case (mode)
      MODE_GROW:
        op.func = roll < 60 ? FN_PUSH : roll < 75 ? FN_DUP : roll < 85 ? FN_PICK :
                  roll < 90 ? FN_EMPTY_TEST : roll < 95 ? FN_SWAP : FN_DROP;
      MODE_SHRINK:
        op.func = roll < 60 ? FN_DROP : roll < 75 ? FN_WORK_TO_RET : roll < 85 ? FN_SWAP :
                  FN_PUSH;
      MODE_TO_RET:
        op.func = roll < 45 ? FN_COPY_TO_RET : roll < 70 ? FN_WORK_TO_RET :
                  roll < 85 ? FN_PUSH : FN_DUP;
      MODE_FROM_RET:
        op.func = roll < 55 ? FN_RET_TO_WORK : roll < 75 ? FN_DROP : roll < 90 ? FN_SWAP :
                  FN_PICK;
      default:
        op.func = (roll < 8) ? FUNC_W'($urandom_range(FN_NOP_HI, FN_NOP_LO)) :
                  FUNC_W'($urandom_range(FN_COPY_TO_RET));
    endcase
    return op;
  endfunction

  function automatic bit calm_window();
    return beats_in >= CALM_FIRST && beats_in < CALM_LAST;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             beats_out, field, got, want);
  endtask

  task automatic add_op(logic [FUNC_W-1:0] f, word_t v, pick_t p);
    stack_op_t op;
    op.func       = f;
    op.value      = v;
    op.pidx       = p;
    op.wait_drain = 1'b0;
    pending_ops.push_back(op);
    queued_total++;
  endtask

  // Driver: predict on each accepted beat, then offer the next pending op
  always @(posedge clk) begin : driver_blk
    bit fire;
    bit load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        expected_res.push_back(apply_stack_op(cur_op));
        beats_in++;
      end
      if (!in_valid || fire) begin
        load = pending_ops.size() > 0 && (calm_window() || $urandom_range(99) >= IDLE_PCT);
        // hold the sender until every outstanding result is back
        if (load && pending_ops[0].wait_drain && expected_res.size() > 0) load = 1'b0;
        if (load) begin
          cur_op = pending_ops.pop_front();
          in_valid   <= 1'b1;
          func       <= cur_op.func;
          push_value <= cur_op.value;
          pick_index <= cur_op.pidx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold that backs up the input
  always @(posedge clk) begin : backpressure_blk
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin : monitor_blk
    stack_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        report("unexpected result, value_out", value_out, '0);
      end else begin
        want = expected_res.pop_front();
        if (value_out !== want.value) report("value_out", value_out, want.value);
        if (work_depth !== want.wdepth)
          report("work_depth", 32'(work_depth), 32'(want.wdepth));
        if (return_depth !== want.rdepth)
          report("return_depth", 32'(return_depth), 32'(want.rdepth));
        if (status !== want.status) report("status", 32'(status), 32'(want.status));
      end
      beats_out++;
    end
  end

  always @(posedge clk) begin : watchdog_blk
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus_blk
    stack_op_t op;
    gen_mode_t mode;
    int        batch;
    int        len;
    int        made;

    // Every op below underflows on the empty stacks
    add_op(FN_DROP, '0, '0);
    add_op(FN_DUP, '0, '0);
    add_op(FN_SWAP, '0, '0);
    add_op(FN_PICK, '0, '0);
    add_op(FN_WORK_TO_RET, '0, '0);
    add_op(FN_RET_TO_WORK, '0, '0);
    add_op(FN_COPY_TO_RET, '0, '0);
    // Drop the only element, then test an empty stack
    add_op(FN_PUSH, 32'h8000_0001, '0);
    add_op(FN_DROP, '0, '0);
    add_op(FN_EMPTY_TEST, '0, '0);
    add_op(FN_PUSH, 32'hFFFF_FFFF, '1);
    add_op(FN_PUSH, 32'h0000_0000, '0);
    add_op(FN_SWAP, '0, '0);
    add_op(FN_DUP, '0, '0);
    add_op(FN_PICK, '0, '1);
    add_op(FN_PICK, '0, 6'd2);
    add_op(FN_EMPTY_TEST, '0, '0);
    add_op(FN_COPY_TO_RET, '0, '0);
    add_op(FN_WORK_TO_RET, '0, '0);
    add_op(FN_RET_TO_WORK, '0, '0);
    add_op(FN_NOP_LO, 32'h5A5A_A5A5, 6'h2A);
    add_op(FN_NOP_HI, '1, 6'h15);

    // Random runs; forced long grow and return-fill runs reach both full stacks
    made  = 0;
    batch = 0;
    while (made < RANDOM_OPS) begin
      if (batch % 6 == 0) begin
        mode = MODE_GROW;
        len  = 90;
      end else if (batch % 6 == 3) begin
        mode = MODE_TO_RET;
        len  = 90;
      end else begin
        mode = gen_mode_t'($urandom_range(MODE_MIX));
        len  = $urandom_range(16, 64);
      end
      for (int i = 0; i < len; i++) begin
        op = make_op(mode);
        op.wait_drain = (i == 0) && (batch % 5 == 0);
        pending_ops.push_back(op);
      end
      made  += len;
      queued_total += len;
      batch++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beats_in < queued_total || expected_res.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
